// File: src/sdcw_pkg.sv
package sdcw_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 30;
  localparam int unsigned HoldW    = 30;
  localparam int unsigned ElapsedW = 27;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_RESET = 2'd0,
    CFG_JOG_SPEED  = 2'd1,
    CFG_HOLD_TIME  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  localparam logic signed [7:0] ModePosition = 8'sd1;
  localparam logic signed [7:0] ModeVelocity = 8'sd2;
  localparam logic signed [7:0] ModeHoming   = 8'sd6;

  localparam logic [HoldW-1:0]   HoldTimeRst = 30'd100000000;
  localparam logic signed [15:0] JogSpeedRst = 16'sd1;
  localparam logic signed [15:0] JogSpeedMin = 16'sh8000;
  localparam logic signed [15:0] JogSpeedMax = 16'sh7fff;

  typedef struct packed {
    logic [15:0]         status_word;
    logic signed [7:0]   mode_reported;
    logic                enable_request;
    logic                fault_reset_request;
    logic                jog_plus;
    logic                jog_minus;
    logic                setpoint_immediate;
    logic                setpoint_set;
    logic                home_set;
    logic [ElapsedW-1:0] elapsed_ns;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       control_word;
    logic signed [7:0] mode_request;
    logic              fault_out;
    logic              target_reached;
    logic              setpoint_pending_out;
    logic              home_pending_out;
    logic              homed_flag;
    logic              homing_flag;
    logic              home_error;
    logic              velocity_write;
    logic signed [15:0] velocity_value;
  } out_item_t;

  typedef struct packed {
    logic               auto_reset_enable;
    logic signed [15:0] jog_speed;
    logic [HoldW-1:0]   fault_hold_time;
  } cfg_t;

endpackage

// File: src/sdcw_core.sv
module sdcw_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sdcw_pkg::cfg_t     cfg_i,
  input  sdcw_pkg::in_item_t item_i,
  output sdcw_pkg::out_item_t res_o
);

  logic enable_prev_q, enable_prev_d;
  logic jog_plus_prev_q, jog_plus_prev_d;
  logic jog_minus_prev_q, jog_minus_prev_d;
  logic ack_prev_q, ack_prev_d;
  logic sp_pend_q, sp_pend_d;
  logic home_pend_q, home_pend_d;
  logic homed_q, homed_d;
  logic homing_q, homing_d;
  logic home_err_q, home_err_d;
  logic [sdcw_pkg::HoldW-1:0] hold_q, hold_d;
  logic signed [7:0] mode_q, mode_d;

  logic [15:0] st;
  logic pp, vel, hom, fault, ack, target, fault_out, edge_en, jog_edge;
  logic jp, jm, sp_raised, hm_raised;
  logic [15:0] control;
  logic signed [15:0] velo;
  logic [sdcw_pkg::HoldW-1:0] elapsed_ext;

  always_comb begin
    st  = item_i.status_word;
    jp  = item_i.jog_plus;
    jm  = item_i.jog_minus;
    pp  = item_i.mode_reported == sdcw_pkg::ModePosition;
    vel = item_i.mode_reported == sdcw_pkg::ModeVelocity;
    hom = item_i.mode_reported == sdcw_pkg::ModeHoming;
    fault = st[3];
    elapsed_ext = {{(sdcw_pkg::HoldW-sdcw_pkg::ElapsedW){1'b0}}, item_i.elapsed_ns};

    sp_raised = sp_pend_q | item_i.setpoint_set;
    hm_raised = home_pend_q | item_i.home_set;

    target = (pp | vel) & st[10];

    ack = pp & st[12];
    sp_pend_d  = sp_raised & ~(ack & ~ack_prev_q);
    ack_prev_d = ack;

    homed_d     = homed_q;
    homing_d    = homing_q;
    home_err_d  = home_err_q;
    home_pend_d = hm_raised;
    if (hom && hm_raised) begin
      homed_d    = st[10] & st[12];
      homing_d   = ~st[12] & ~st[10];
      home_err_d = st[13];
      if (homed_d && !homed_q && !homing_d) begin
        home_pend_d = 1'b0;
      end
    end

    if (hold_q != '0) begin
      hold_d    = (hold_q > elapsed_ext) ? hold_q - elapsed_ext : '0;
      fault_out = 1'b0;
    end else begin
      hold_d    = hold_q;
      fault_out = fault & item_i.enable_request;
    end

    edge_en       = item_i.enable_request & ~enable_prev_q;
    enable_prev_d = item_i.enable_request;

    control = 16'h0004;
    if (fault) begin
      if (item_i.fault_reset_request) begin
        control[7] = 1'b1;
      end
      if (cfg_i.auto_reset_enable && edge_en) begin
        hold_d     = cfg_i.fault_hold_time;
        control[7] = 1'b1;
      end
    end else if (item_i.enable_request) begin
      control[1] = 1'b1;
      if (st[0]) begin
        control[0] = 1'b1;
        control[3] = st[1];
      end
    end

    if (pp) begin
      control[4] = sp_pend_d;
    end else if (vel) begin
      control[4] = jp | jm;
    end else if (hom) begin
      control[4] = home_pend_d;
    end
    control[5] = item_i.setpoint_immediate;

    jog_edge         = (jp & ~jog_plus_prev_q) | (jm & ~jog_minus_prev_q);
    jog_plus_prev_d  = jp;
    jog_minus_prev_d = jm;
    if (jp) begin
      velo = cfg_i.jog_speed;
    end else if (cfg_i.jog_speed == sdcw_pkg::JogSpeedMin) begin
      velo = sdcw_pkg::JogSpeedMax;
    end else begin
      velo = -cfg_i.jog_speed;
    end

    mode_d = mode_q;
    if (st[2] && jog_edge) begin
      mode_d = sdcw_pkg::ModeVelocity;
    end
    if (!jp && !jm && !home_pend_d) begin
      mode_d = sdcw_pkg::ModePosition;
    end
    if (home_pend_d) begin
      mode_d = sdcw_pkg::ModeHoming;
    end

    res_o.control_word         = control;
    res_o.mode_request         = mode_d;
    res_o.fault_out            = fault_out;
    res_o.target_reached       = target;
    res_o.setpoint_pending_out = sp_pend_d;
    res_o.home_pending_out     = home_pend_d;
    res_o.homed_flag           = homed_d;
    res_o.homing_flag          = homing_d;
    res_o.home_error           = home_err_d;
    res_o.velocity_write       = jog_edge;
    res_o.velocity_value       = velo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_prev_q    <= 1'b0;
      jog_plus_prev_q  <= 1'b0;
      jog_minus_prev_q <= 1'b0;
      ack_prev_q       <= 1'b0;
      sp_pend_q        <= 1'b0;
      home_pend_q      <= 1'b0;
      homed_q          <= 1'b0;
      homing_q         <= 1'b0;
      home_err_q       <= 1'b0;
      hold_q           <= '0;
      mode_q           <= sdcw_pkg::ModePosition;
    end else if (step_i) begin
      enable_prev_q    <= enable_prev_d;
      jog_plus_prev_q  <= jog_plus_prev_d;
      jog_minus_prev_q <= jog_minus_prev_d;
      ack_prev_q       <= ack_prev_d;
      sp_pend_q        <= sp_pend_d;
      home_pend_q      <= home_pend_d;
      homed_q          <= homed_d;
      homing_q         <= homing_d;
      home_err_q       <= home_err_d;
      hold_q           <= hold_d;
      mode_q           <= mode_d;
    end
  end

endmodule

// File: src/servo_drive_control_word_sequencer.sv
// dataflow: an accepted input item is held in the input register, and the
// sequencer step writes its result into the result register; one item per cycle
// while the result side takes each result, else the step and the input stall
// reset: all handshake and jog state cleared, hold timer zero, mode request
// position, config registers at their defaults
module servo_drive_control_word_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sdcw_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sdcw_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [sdcw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sdcw_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic                in_valid_q;
  sdcw_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  sdcw_pkg::out_item_t out_item_q;
  sdcw_pkg::out_item_t res;
  sdcw_pkg::cfg_t      cfg_q;
  logic                step;
  sdcw_pkg::cfg_idx_e  cfg_idx;

  assign step       = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | step;
  assign cfg_idx    = sdcw_pkg::cfg_idx_e'(cfg_idx_i);

  sdcw_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg_q),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.auto_reset_enable <= 1'b1;
      cfg_q.jog_speed         <= sdcw_pkg::JogSpeedRst;
      cfg_q.fault_hold_time   <= sdcw_pkg::HoldTimeRst;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx)
          sdcw_pkg::CFG_AUTO_RESET: cfg_q.auto_reset_enable <= cfg_data_i[0];
          sdcw_pkg::CFG_JOG_SPEED:  cfg_q.jog_speed         <= cfg_data_i[15:0];
          sdcw_pkg::CFG_HOLD_TIME:  cfg_q.fault_hold_time   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sdcw_pkg::*;

  localparam int PipeLatency = 2;
  localparam int CycleLimit = 200000;
  localparam logic [ElapsedW-1:0] ElapsedMax = 27'd100000000;
  localparam logic [HoldW-1:0] HoldTimeMax = 30'd1000000000;
  localparam logic signed [7:0] ModeNone = 8'sd0;

  localparam logic [15:0] StReady   = 16'h0001;
  localparam logic [15:0] StOn      = 16'h0002;
  localparam logic [15:0] StOpEn    = 16'h0004;
  localparam logic [15:0] StFault   = 16'h0008;
  localparam logic [15:0] StTarget  = 16'h0400;
  localparam logic [15:0] StAck     = 16'h1000;
  localparam logic [15:0] StHomeErr = 16'h2000;

  localparam logic [15:0] CwSwitchOn  = 16'h0001;
  localparam logic [15:0] CwEnVolt    = 16'h0002;
  localparam logic [15:0] CwQuickStop = 16'h0004;
  localparam logic [15:0] CwEnOp      = 16'h0008;
  localparam logic [15:0] CwModeBit   = 16'h0010;
  localparam logic [15:0] CwImmediate = 16'h0020;
  localparam logic [15:0] CwFaultRst  = 16'h0080;

  // request flags of a directed item
  localparam logic [6:0] FEn  = 7'b1000000;
  localparam logic [6:0] FRst = 7'b0100000;
  localparam logic [6:0] FJp  = 7'b0010000;
  localparam logic [6:0] FJm  = 7'b0001000;
  localparam logic [6:0] FImm = 7'b0000100;
  localparam logic [6:0] FSp  = 7'b0000010;
  localparam logic [6:0] FHm  = 7'b0000001;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  servo_drive_control_word_sequencer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predicted drive state
  logic auto_rst_cfg = 1'b1;
  logic signed [15:0] jog_speed_cfg = JogSpeedRst;
  logic [HoldW-1:0] hold_time_cfg = HoldTimeRst;
  logic en_was = 1'b0, jp_was = 1'b0, jm_was = 1'b0, ack_was = 1'b0;
  logic sp_req = 1'b0, home_req = 1'b0;
  logic homed = 1'b0, homing = 1'b0, home_err = 1'b0;
  logic [HoldW-1:0] hold_left = '0;
  logic signed [7:0] mode_now = ModePosition;

  out_item_t drive_results_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_run = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;

  // sticky host and drive state for random traffic
  logic signed [7:0] live_mode = ModePosition;
  logic live_en = 1'b0, live_jp = 1'b0, live_jm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, drive_results_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic out_item_t predict_drive_cycle(in_item_t it);
    out_item_t r;
    logic [15:0] sw;
    logic [15:0] cw;
    logic pp, vel, hom, fault, ack, tgt, fout, en_rise, jog_rise, was_homed;
    int velo;
    sw = it.status_word;
    pp = it.mode_reported == ModePosition;
    vel = it.mode_reported == ModeVelocity;
    hom = it.mode_reported == ModeHoming;
    fault = |(sw & StFault);
    if (it.setpoint_set) sp_req = 1'b1;
    if (it.home_set) home_req = 1'b1;

    tgt = (pp || vel) ? |(sw & StTarget) : 1'b0;
    ack = pp ? |(sw & StAck) : 1'b0;
    if (sp_req && ack && !ack_was) sp_req = 1'b0;
    ack_was = ack;

    if (hom && home_req) begin
      was_homed = homed;
      homed = |(sw & StTarget) && |(sw & StAck);
      homing = !(|(sw & StAck)) && !(|(sw & StTarget));
      home_err = |(sw & StHomeErr);
      if (homed && !was_homed && !homing) home_req = 1'b0;
    end

    if (hold_left != '0) begin
      hold_left = (hold_left > HoldW'(it.elapsed_ns)) ?
                  hold_left - HoldW'(it.elapsed_ns) : '0;
      fout = 1'b0;
    end else begin
      fout = fault && it.enable_request;
    end

    en_rise = it.enable_request && !en_was;
    en_was = it.enable_request;
    cw = CwQuickStop;
    if (fault) begin
      if (it.fault_reset_request) cw |= CwFaultRst;
      if (auto_rst_cfg && en_rise) begin
        hold_left = hold_time_cfg;
        cw |= CwFaultRst;
      end
    end else if (it.enable_request) begin
      cw |= CwEnVolt;
      if (|(sw & StReady)) begin
        cw |= CwSwitchOn;
        if (|(sw & StOn)) cw |= CwEnOp;
      end
    end
    if (pp) begin
      if (sp_req) cw |= CwModeBit;
    end else if (vel) begin
      if (it.jog_plus || it.jog_minus) cw |= CwModeBit;
    end else if (hom) begin
      if (home_req) cw |= CwModeBit;
    end
    if (it.setpoint_immediate) cw |= CwImmediate;

    jog_rise = (it.jog_plus && !jp_was) || (it.jog_minus && !jm_was);
    jp_was = it.jog_plus;
    jm_was = it.jog_minus;
    velo = it.jog_plus ? int'(jog_speed_cfg) : -int'(jog_speed_cfg);
    if (velo > 32767) velo = 32767;

    if (|(sw & StOpEn) && jog_rise) mode_now = ModeVelocity;
    if (!it.jog_plus && !it.jog_minus && !home_req) mode_now = ModePosition;
    if (home_req) mode_now = ModeHoming;

    r.control_word = cw;
    r.mode_request = mode_now;
    r.fault_out = fout;
    r.target_reached = tgt;
    r.setpoint_pending_out = sp_req;
    r.home_pending_out = home_req;
    r.homed_flag = homed;
    r.homing_flag = homing;
    r.home_error = home_err;
    r.velocity_write = jog_rise;
    r.velocity_value = velo[15:0];
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_results_q.size() == 0) begin
        $display("%0t: unexpected item expected none got %p", $time, out_item);
        errors++;
      end else begin
        want = drive_results_q.pop_front();
        check_field("control_word", int'(want.control_word), int'(out_item.control_word));
        check_field("mode_request", int'(want.mode_request), int'(out_item.mode_request));
        check_field("fault_out", int'(want.fault_out), int'(out_item.fault_out));
        check_field("target_reached", int'(want.target_reached),
                    int'(out_item.target_reached));
        check_field("setpoint_pending_out", int'(want.setpoint_pending_out),
                    int'(out_item.setpoint_pending_out));
        check_field("home_pending_out", int'(want.home_pending_out),
                    int'(out_item.home_pending_out));
        check_field("homed_flag", int'(want.homed_flag), int'(out_item.homed_flag));
        check_field("homing_flag", int'(want.homing_flag), int'(out_item.homing_flag));
        check_field("home_error", int'(want.home_error), int'(out_item.home_error));
        check_field("velocity_write", int'(want.velocity_write),
                    int'(out_item.velocity_write));
        check_field("velocity_value", int'(want.velocity_value),
                    int'(out_item.velocity_value));
        results_checked++;
      end
    end
    if (rst_n && in_valid && in_ready) begin
      drive_results_q.push_back(predict_drive_cycle(in_item));
    end
  end

  // result side: random stall before each item
  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic send_cmd(logic [15:0] sw, logic signed [7:0] mode, logic [6:0] flags,
                          logic [ElapsedW-1:0] elapsed);
    in_item_t it;
    it.status_word = sw;
    it.mode_reported = mode;
    {it.enable_request, it.fault_reset_request, it.jog_plus, it.jog_minus,
     it.setpoint_immediate, it.setpoint_set, it.home_set} = flags;
    it.elapsed_ns = elapsed;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (drive_results_q.size() != 0);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task automatic write_settings(logic auto_rst, logic signed [15:0] jog,
                                logic [HoldW-1:0] hold);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_AUTO_RESET;
    cfg_data <= CfgDataW'(auto_rst);
    @(posedge clk);
    cfg_idx <= CFG_JOG_SPEED;
    cfg_data <= CfgDataW'(16'(jog));
    @(posedge clk);
    cfg_idx <= CFG_HOLD_TIME;
    cfg_data <= hold;
    @(posedge clk);
    cfg_idx <= CFG_UNUSED;
    cfg_data <= CfgDataW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    auto_rst_cfg = auto_rst;
    jog_speed_cfg = jog;
    hold_time_cfg = hold;
    settings_run++;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: live_mode = ModeNone;
        1: live_mode = ModePosition;
        2: live_mode = ModeVelocity;
        3: live_mode = ModeHoming;
        default: live_mode = 8'($urandom);
      endcase
    end
    if ($urandom_range(0, 7) == 0) live_en = !live_en;
    if ($urandom_range(0, 5) == 0) live_jp = !live_jp;
    if ($urandom_range(0, 5) == 0) live_jm = !live_jm;
    it.status_word = 16'($urandom);
    if ($urandom_range(0, 3) != 0) it.status_word &= ~StFault;
    it.mode_reported = live_mode;
    it.enable_request = live_en;
    it.fault_reset_request = ($urandom_range(0, 7) == 0);
    it.jog_plus = live_jp;
    it.jog_minus = live_jm;
    it.setpoint_immediate = 1'($urandom_range(0, 1));
    it.setpoint_set = ($urandom_range(0, 7) == 0);
    it.home_set = ($urandom_range(0, 15) == 0);
    case ($urandom_range(0, 9))
      0: it.elapsed_ns = '0;
      1: it.elapsed_ns = ElapsedMax;
      2, 3, 4: it.elapsed_ns = ElapsedW'($urandom_range(0, ElapsedMax));
      default: it.elapsed_ns = ElapsedW'($urandom_range(0, 1000));
    endcase
    return it;
  endfunction

  task automatic test_field_extremes();
    send_cmd(16'h0000, ModeNone, 7'b0, '0);
    send_cmd(16'hffff, -8'sd128, 7'h7f, ElapsedMax);
    send_cmd(16'h0000, 8'sd127, 7'b0, '0);
  endtask

  task automatic test_fault_recovery();
    send_cmd(16'h0000, ModePosition, 7'b0, ElapsedMax);
    send_cmd(StReady | StOn | StOpEn, ModePosition, FEn, 27'd10);
    send_cmd(StFault, ModePosition, FEn, '0);
    send_cmd(StFault, ModePosition, FEn | FRst, 27'd5);
    send_cmd(StFault, ModePosition, 7'b0, ElapsedMax);
    send_cmd(StFault, ModePosition, FEn, 27'd40000000);
    send_cmd(StFault, ModePosition, FEn, ElapsedMax);
    send_cmd(StFault, ModePosition, FEn, '0);
  endtask

  task automatic test_setpoint_handshake();
    send_cmd(StReady, ModePosition, FSp, 27'd1);
    send_cmd(StAck | StTarget, ModePosition, FImm, 27'd1);
    send_cmd(StAck, ModePosition, FSp, 27'd1);
    send_cmd(16'h0000, ModePosition, 7'b0, 27'd1);
  endtask

  task automatic test_homing();
    send_cmd(16'h0000, ModeHoming, FHm, 27'd1);
    send_cmd(StTarget | StAck, ModeHoming, 7'b0, 27'd1);
    send_cmd(StHomeErr, ModeHoming, FHm, 27'd1);
  endtask

  task automatic test_jog();
    send_cmd(StOpEn, ModeVelocity, FJp, 27'd1);
    send_cmd(StOpEn, ModeVelocity, FJp, 27'd1);
    send_cmd(StOpEn, ModeVelocity, FJm, 27'd1);
    send_cmd(StOpEn, ModeVelocity, 7'b0, 27'd1);
  endtask

  task automatic test_unknown_modes();
    send_cmd(StAck | StTarget, 8'sd3, FSp | FJp, 27'd1);
    send_cmd(StAck | StTarget, -8'sd1, 7'b0, 27'd1);
  endtask

  task automatic test_jog_speed_limits();
    write_settings(1'b0, JogSpeedMin, '0);
    send_cmd(StOpEn | StFault, ModeVelocity, FJm | FEn, 27'd1);
    send_cmd(StOpEn, ModeVelocity, FJp | FJm, 27'd1);
    write_settings(1'b1, JogSpeedMax, '0);
    send_cmd(StOpEn, ModeVelocity, FJm, 27'd1);
    send_cmd(StFault, ModeVelocity, FJp | FEn, 27'd1);
  endtask

  task automatic test_random_traffic();
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: write_settings(1'b1, JogSpeedRst, HoldTimeRst);
        1: write_settings(1'b0, JogSpeedMax, HoldTimeMax);
        2: write_settings(1'b1, JogSpeedMin, '0);
        3: write_settings(1'b1, 16'($urandom), HoldW'($urandom_range(1, 5000)));
        default: write_settings(1'b1, 16'($urandom), HoldTimeMax);
      endcase
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_item(random_item());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_fault_recovery();
    test_setpoint_handshake();
    test_homing();
    test_jog();
    test_unknown_modes();
    test_jog_speed_limits();
    test_random_traffic();
    wait_idle();
    $display("sent %0d items under %0d register settings, checked %0d results",
             items_sent, settings_run, results_checked);
    $display("covered fault masking, setpoint and homing handshakes, jog and mode changes");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
